[design/bhil_pkg.sv]
// Shared types, widths and status codes for the bucketed hash table.
package bhil_pkg;

  localparam int KEY_W    = 49;
  localparam int ID_SHIFT = 17;
  localparam int CFG_W    = 10;
  localparam int OVF_W    = 11;

  localparam int DEF_SLOTS_PER_BUCKET = 8;
  localparam int DEF_TOTAL_BUCKETS    = 1024;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_DUP_ERR   = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic REG_HEADER   = 1'b0;
  localparam logic REG_OVERFLOW = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] key_id;
    logic        key_dir;
    logic [15:0] key_predicate;
    logic [31:0] key_hash;
    logic        reject_duplicate;
  } in_item_t;

  typedef struct packed {
    logic [12:0] slot_index;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } div_rsp_t;

endpackage

[design/bhil_div.sv]
// Bit-serial restoring remainder unit: 32-bit dividend modulo a 10-bit divisor.
module bhil_div import bhil_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0]      dvd_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] dsr_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CFG_W:0]   trial;
  logic [CFG_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[31]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = CFG_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

[design/bucketed_hash_insert_lookup.sv]
// Bucketed hash table with overflow chaining: insert and lookup over one slot memory.
// The start bucket comes from the bit-serial modulo unit, then the slots are read in turn
// through the single-port slot memory (S_RD, S_CHK). Linking an overflow bucket adds a
// link write and a key write; the result is registered. One item in flight at a time.
// Reset: a clearing pass writes zero to all TOTAL_BUCKETS*SLOTS_PER_BUCKET slots,
// one per cycle, while no item is taken.
module bucketed_hash_insert_lookup import bhil_pkg::*; #(
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET,
  parameter int TOTAL_BUCKETS    = DEF_TOTAL_BUCKETS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_psel,
  input  logic      cfg_penable,
  input  logic      cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DEPTH = TOTAL_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = $clog2(DEPTH);
  localparam int BKW   = $clog2(TOTAL_BUCKETS);
  localparam int SW    = $clog2(SLOTS_PER_BUCKET);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_WLNK = 3'd5;
  localparam logic [2:0] S_WNEW = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [KEY_W-1:0] mem_wdata;

  logic [2:0]       state_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [CFG_W-1:0] hb_r;
  logic [CFG_W-1:0] ob_r;
  logic [OVF_W-1:0] ovf_used_r;
  logic [KEY_W-1:0] key_r;
  logic             lookup_r;
  logic             reject_r;
  logic [31:0]      hash_r;
  logic [BKW-1:0]   bucket_r;
  logic [SW-1:0]    idx_r;
  logic [BKW-1:0]   hops_r;
  logic [BKW-1:0]   fresh_r;
  out_item_t        res_r;
  out_item_t        out_data_r;
  logic             out_valid_r;
  logic             div_start_r;

  div_req_t         dreq;
  div_rsp_t         drsp;

  logic [CFG_W-1:0] hb_eff;
  logic [AW-1:0]    slot_addr;
  logic [31:0]      slot32;
  logic [KEY_W-1:0] in_key;
  logic [31:0]      link_next;
  logic [31:0]      fresh32;
  logic             cfg_wr;

  always_comb begin
    if (hb_r == '0) begin
      hb_eff = CFG_W'(1);
    end else if (32'(hb_r) > 32'(TOTAL_BUCKETS)) begin
      hb_eff = CFG_W'(TOTAL_BUCKETS);
    end else begin
      hb_eff = hb_r;
    end
  end

  assign slot_addr = AW'(AW'(bucket_r) * AW'(SLOTS_PER_BUCKET)) + AW'(idx_r);
  assign slot32    = 32'(slot_addr);
  assign in_key    = {in_data.key_id, in_data.key_dir, in_data.key_predicate};
  assign link_next = rd_data_r[KEY_W-1:ID_SHIFT];
  assign fresh32   = 32'(hb_eff) + 32'(ovf_used_r);

  assign dreq.start    = div_start_r;
  assign dreq.dividend = hash_r;
  assign dreq.divisor  = hb_eff;

  bhil_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot_addr;
    mem_wdata = key_r;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      S_CHK: begin
        mem_we = (!lookup_r) && (32'(idx_r) != 32'(SLOTS_PER_BUCKET - 1)) &&
                 (rd_data_r == '0);
      end
      S_WLNK: begin
        mem_we    = 1'b1;
        mem_wdata = KEY_W'({fresh_r, {ID_SHIFT{1'b0}}});
      end
      S_WNEW: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r <= CFG_W'(768);
      ob_r <= CFG_W'(256);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_HEADER) begin
        hb_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        ob_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OVERFLOW) ? 32'(ob_r) : 32'(hb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      ovf_used_r  <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (32'(clr_cnt_r) == 32'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key_r    <= in_key;
            lookup_r <= (in_data.mode == MODE_LOOKUP);
            reject_r <= in_data.reject_duplicate;
            hash_r   <= in_data.key_hash;
            if (in_key == '0) begin
              res_r   <= '{slot_index: 13'd0, status: ST_NOT_FOUND};
              state_r <= S_DONE;
            end else begin
              div_start_r <= 1'b1;
              state_r     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            bucket_r <= BKW'(drsp.rem);
            idx_r    <= '0;
            hops_r   <= '0;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (32'(idx_r) != 32'(SLOTS_PER_BUCKET - 1)) begin
            if (rd_data_r == key_r) begin
              if (!lookup_r && reject_r) begin
                res_r <= '{slot_index: 13'd0, status: ST_DUP_ERR};
              end else begin
                res_r <= '{slot_index: slot32[12:0], status: ST_PRESENT};
              end
              state_r <= S_DONE;
            end else if (!lookup_r && rd_data_r == '0) begin
              res_r   <= '{slot_index: slot32[12:0], status: ST_INSERTED};
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r + SW'(1);
              state_r <= S_RD;
            end
          end else if (rd_data_r != '0) begin
            if (link_next >= 32'(TOTAL_BUCKETS) ||
                32'(hops_r) == 32'(TOTAL_BUCKETS - 1)) begin
              res_r   <= '{slot_index: 13'd0,
                           status: lookup_r ? ST_NOT_FOUND : ST_EXHAUSTED};
              state_r <= S_DONE;
            end else begin
              bucket_r <= BKW'(link_next);
              idx_r    <= '0;
              hops_r   <= hops_r + BKW'(1);
              state_r  <= S_RD;
            end
          end else if (lookup_r) begin
            res_r   <= '{slot_index: 13'd0, status: ST_NOT_FOUND};
            state_r <= S_DONE;
          end else if (ovf_used_r >= OVF_W'(ob_r) || fresh32 >= 32'(TOTAL_BUCKETS)) begin
            res_r   <= '{slot_index: 13'd0, status: ST_EXHAUSTED};
            state_r <= S_DONE;
          end else begin
            fresh_r <= BKW'(fresh32);
            state_r <= S_WLNK;
          end
        end
        S_WLNK: begin
          ovf_used_r <= ovf_used_r + OVF_W'(1);
          bucket_r   <= fresh_r;
          idx_r      <= '0;
          state_r    <= S_WNEW;
        end
        S_WNEW: begin
          res_r   <= '{slot_index: slot32[12:0], status: ST_INSERTED};
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("item taken during clearing pass");

  a_ovf_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_used_r != $past(ovf_used_r)) |-> (ovf_used_r == $past(ovf_used_r) + OVF_W'(1)))
    else $error("overflow count moved by more than one");

  a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WLNK) |=> (state_r == S_WNEW))
    else $error("link write not followed by key write");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwrote a pending transfer");
`endif

endmodule
